[rtl/crc_pkg.sv]
// ----------------------------------------------------------------------------
// CRC byte engine package
// Shared types, register codes and the bytewise CRC fold function.
// ----------------------------------------------------------------------------
package crc_pkg;

	// Widths of the word fields.
	localparam int CRC_W      = 32;
	localparam int BYTE_W     = 8;
	localparam int REG_IDX_W  = 2;

	// The byte is folded into bits 31..24 in normal mode.
	localparam int CRC_BYTE_SHIFT = 24;
	localparam int CRC_BYTE_BITS  = 8;

	// Default queue depth between the front and back parts.
	localparam int QUEUE_DEPTH_DEFAULT = 4;

	// Register reset values.
	localparam logic [CRC_W-1:0] POLY_RESET = 32'hEDB88320;
	localparam logic             ORDER_RESET = 1'b0;

	// Register indexes of the configuration port.
	typedef enum logic [REG_IDX_W-1:0] {
		REG_POLYNOMIAL = 2'd0,
		REG_BIT_ORDER  = 2'd1
	} reg_idx_t;

	// Bit order codes.
	localparam logic ORDER_REFLECTED = 1'b0;
	localparam logic ORDER_NORMAL    = 1'b1;

	// One input word as it travels through the queue.
	typedef struct packed {
		logic [BYTE_W-1:0] data_byte;
		logic              first_byte;
		logic [CRC_W-1:0]  seed;
		logic              last_byte;
	} item_t;

	// Queue status seen by both sides.
	typedef struct packed {
		logic full;
		logic empty;
	} queue_status_t;

	// Fold one byte into the CRC with eight shift/XOR steps.
	function automatic logic [CRC_W-1:0] crc_fold(
		input logic [CRC_W-1:0]  crc_in,
		input logic [BYTE_W-1:0] data,
		input logic [CRC_W-1:0]  poly,
		input logic              order
	);
		logic [CRC_W-1:0] crc;
		crc = crc_in;
		if (order == ORDER_NORMAL) begin
			crc = crc ^ {data, {CRC_BYTE_SHIFT{1'b0}}};
			for (int k = 0; k < CRC_BYTE_BITS; k++) begin
				crc = crc[CRC_W-1] ? ({crc[CRC_W-2:0], 1'b0} ^ poly)
					: {crc[CRC_W-2:0], 1'b0};
			end
		end else begin
			crc = crc ^ {{(CRC_W-BYTE_W){1'b0}}, data};
			for (int k = 0; k < CRC_BYTE_BITS; k++) begin
				crc = crc[0] ? ({1'b0, crc[CRC_W-1:1]} ^ poly)
					: {1'b0, crc[CRC_W-1:1]};
			end
		end
		return crc;
	endfunction

endpackage

[rtl/crc32_byte_engine_top.sv]
// ----------------------------------------------------------------------------
// CRC-32 byte engine
// Bytewise CRC with a configurable polynomial and bit order.
// ----------------------------------------------------------------------------
// Usage:
// The input channel (in_valid/in_stall) takes one word per cycle while
// in_stall is low: a data byte, a first-byte flag with its seed, and a
// last-byte flag. The output channel (out_valid/out_stall) returns one word
// per input word: the CRC after that byte and the last-byte flag as
// final_value. A front register takes each word and pushes it into a short
// queue; the back part pops one word per cycle while the output is not
// stalled, folds it into the running CRC with an eight-step shift/XOR
// network and loads the output register. Throughput is one word per cycle
// while neither side stalls, as the fold on the running CRC is
// combinational. When the receiver stalls, the output holds and the queue
// fills; after QUEUE_DEPTH + 2 words are outstanding, in_stall rises.
// Reset clears all valid bits and the running CRC to zero, and loads the
// polynomial 0xEDB88320 in reflected order. Write the registers through
// wr_en/wr_index/wr_data while no word is in flight.
// ----------------------------------------------------------------------------
module crc32_byte_engine_top import crc_pkg::*; #(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 wr_en,
	input  logic [REG_IDX_W-1:0] wr_index,
	input  logic [CRC_W-1:0]     wr_data,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [BYTE_W-1:0]    data_byte,
	input  logic                 first_byte,
	input  logic [CRC_W-1:0]     seed,
	input  logic                 last_byte,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [CRC_W-1:0]     crc_value,
	output logic                 final_value
);

	queue_status_t q_status;
	logic          push;
	item_t         push_item;
	logic          pop;
	item_t         pop_item;

	// Front part: input register.
	crc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.data_byte  (data_byte),
		.first_byte (first_byte),
		.seed       (seed),
		.last_byte  (last_byte),
		.q_status   (q_status),
		.push       (push),
		.push_item  (push_item)
	);

	// Queue between the two parts.
	crc_queue #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.pop_item  (pop_item),
		.q_status  (q_status)
	);

	// Back part: CRC fold and output register.
	crc_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.wr_en       (wr_en),
		.wr_index    (wr_index),
		.wr_data     (wr_data),
		.q_status    (q_status),
		.pop_item    (pop_item),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.crc_value   (crc_value),
		.final_value (final_value)
	);

endmodule

[rtl/crc_front.sv]
// ----------------------------------------------------------------------------
// CRC front stage
// Registers each incoming word and pushes it into the queue when there is room.
// ----------------------------------------------------------------------------
module crc_front import crc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [BYTE_W-1:0] data_byte,
	input  logic              first_byte,
	input  logic [CRC_W-1:0]  seed,
	input  logic              last_byte,
	input  queue_status_t     q_status,
	output logic              push,
	output item_t             push_item
);

	logic  valid_s1;
	item_t item_s1;
	logic  take;

	// The stage holds its word only while the queue is full.
	assign in_stall  = valid_s1 && q_status.full;
	assign take      = in_valid && !in_stall;
	assign push      = valid_s1 && !q_status.full;
	assign push_item = item_s1;

	// Stage valid bit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	// Stage payload.
	always_ff @(posedge clk) begin
		if (take) begin
			item_s1.data_byte  <= data_byte;
			item_s1.first_byte <= first_byte;
			item_s1.seed       <= seed;
			item_s1.last_byte  <= last_byte;
		end
	end

endmodule

[rtl/crc_queue.sv]
// ----------------------------------------------------------------------------
// CRC word queue
// Small first-in first-out buffer between the front and back parts.
// ----------------------------------------------------------------------------
module crc_queue import crc_pkg::*; #(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  item_t         push_item,
	input  logic          pop,
	output item_t         pop_item,
	output queue_status_t q_status
);

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

	item_t            slot_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign q_status.full  = (count_q == FULL_CNT);
	assign q_status.empty = (count_q == '0);
	assign pop_item       = slot_q[rd_ptr_q];

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Storage slots.
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

[rtl/crc_back.sv]
// ----------------------------------------------------------------------------
// CRC back stage
// Holds the configuration, folds each queued byte into the running CRC and
// presents the result in the output register.
// ----------------------------------------------------------------------------
module crc_back import crc_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 wr_en,
	input  logic [REG_IDX_W-1:0] wr_index,
	input  logic [CRC_W-1:0]     wr_data,
	input  queue_status_t        q_status,
	input  item_t                pop_item,
	output logic                 pop,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [CRC_W-1:0]     crc_value,
	output logic                 final_value
);

	logic [CRC_W-1:0] poly_q;
	logic             order_q;
	logic [CRC_W-1:0] running_crc_q;
	logic             out_valid_q;
	logic [CRC_W-1:0] crc_value_q;
	logic             final_value_q;
	logic [CRC_W-1:0] base;
	logic [CRC_W-1:0] next_crc;

	// Take a word whenever the output register is free or being emptied.
	assign pop = !q_status.empty && (!out_valid_q || !out_stall);

	// Fold the byte into the seed or the running CRC.
	assign base     = pop_item.first_byte ? pop_item.seed : running_crc_q;
	assign next_crc = crc_fold(base, pop_item.data_byte, poly_q, order_q);

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			poly_q  <= POLY_RESET;
			order_q <= ORDER_RESET;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_POLYNOMIAL: poly_q  <= wr_data;
				REG_BIT_ORDER:  order_q <= wr_data[0];
				default: ;
			endcase
		end
	end

	// Running CRC and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_crc_q <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			if (pop) begin
				running_crc_q <= next_crc;
				out_valid_q   <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q   <= 1'b0;
			end
		end
	end

	// Output payload.
	always_ff @(posedge clk) begin
		if (pop) begin
			crc_value_q   <= next_crc;
			final_value_q <= pop_item.last_byte;
		end
	end

	assign out_valid   = out_valid_q;
	assign crc_value   = crc_value_q;
	assign final_value = final_value_q;

endmodule

[rtl/crc_checker.sv]
// ----------------------------------------------------------------------------
// CRC engine checker
// Port-level assertions on word flow and occupancy, bound to the top level.
// ----------------------------------------------------------------------------
module crc_checker import crc_pkg::*; #(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
	input logic             clk,
	input logic             arst_n,
	input logic             in_valid,
	input logic             in_stall,
	input logic             out_valid,
	input logic             out_stall,
	input logic [CRC_W-1:0] crc_value,
	input logic             final_value
);

	localparam int CAPACITY = QUEUE_DEPTH + 2;
	localparam int OCC_W    = $clog2(CAPACITY + 2);
	localparam logic [OCC_W-1:0] CAP_OCC = OCC_W'(CAPACITY);

	logic             in_take;
	logic             out_take;
	logic [OCC_W-1:0] occ_q;

	assign in_take  = in_valid && !in_stall;
	assign out_take = out_valid && !out_stall;

	// Words accepted but not yet delivered.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= '0;
		end else if (in_take && !out_take) begin
			occ_q <= occ_q + 1'b1;
		end else if (out_take && !in_take) begin
			occ_q <= occ_q - 1'b1;
		end
	end

	// A stalled result holds its value.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(crc_value) && $stable(final_value))
		else $error("stalled output word changed");

	// No result appears without an accepted input word behind it.
	a_no_invent: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> occ_q != '0)
		else $error("output word without matching input word");

	// Occupancy never exceeds the storage of the block.
	a_capacity: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= CAP_OCC)
		else $error("more words in flight than the block can hold");

	// An empty block never stalls its source.
	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q == '0 |-> !in_stall)
		else $error("input stalled while the block is empty");

endmodule

bind crc32_byte_engine_top crc_checker #(
	.QUEUE_DEPTH (QUEUE_DEPTH)
) u_crc_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_stall    (in_stall),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.crc_value   (crc_value),
	.final_value (final_value)
);
